>>> src/cell_hit_accumulator_top_macros.svh
// Assertion macros for the cell hit accumulator.
// Included by cell_hit_accumulator_top.sv; no other dependencies.
`ifndef CELL_HIT_ACCUMULATOR_TOP_MACROS_SVH
`define CELL_HIT_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHACC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chacc assertion failed");

// Next-cycle implication, disabled during reset
`define CHACC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chacc assertion failed");

`endif

>>> src/chacc_pkg.sv
// Shared types and constants of the cell hit accumulator.
// No dependencies; used by every module of the block.
`default_nettype none

package chacc_pkg;

    // Fixed field widths
    localparam int DEP_W     = 24;
    localparam int CELL_ID_W = 11;
    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 10;
    localparam int OUT_E_W   = 32;

    // Command codes
    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_START   = 1'b1;

    // Event epoch marks; zero marks a cleared cell
    localparam int                 EPOCH_W     = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item class decided by the front
    typedef enum logic [1:0] {
        KIND_DEPOSIT,
        KIND_START,
        KIND_DROP,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CELL_ID_W-1:0] cell_id;
        logic [DEP_W-1:0]     energy;
    } t_qitem;

    typedef struct packed {
        logic                 dropped;
        logic                 bad_cell;
        logic                 new_hit;
        logic [OUT_IDX_W-1:0] hit_index;
        logic [OUT_E_W-1:0]   cell_energy;
        logic [OUT_CNT_W-1:0] hit_count;
    } t_result;

    typedef struct packed {
        logic sweeping;
        logic busy;
    } t_bstat;

    typedef enum logic [1:0] {
        BS_SWEEP,
        BS_IDLE,
        BS_READ
    } t_bstate;

endpackage

`default_nettype wire

>>> src/chacc_front.sv
// Front end: accepts input transactions, classifies them, forms the cell address.
// Depends on chacc_pkg.
`default_nettype none

module chacc_front #(
    parameter int Z_CELLS   = 20,
    parameter int PHI_CELLS = 48
) (
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_cmd,
    input  wire logic [4:0]                      i_z_cell,
    input  wire logic [5:0]                      i_phi_cell,
    input  wire logic [chacc_pkg::DEP_W-1:0]     i_deposit_energy,
    input  wire logic                            i_full,
    output logic                                 o_push,
    output chacc_pkg::t_qitem                    o_item
);

    logic z_bad;
    logic phi_bad;

    // Range checks against the grid size
    assign z_bad   = 6'(i_z_cell) >= 6'(Z_CELLS);
    assign phi_bad = 7'(i_phi_cell) >= 7'(PHI_CELLS);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Classification: start, zero deposit, bad cell, then real deposit
    always_comb begin
        o_item.cell_id = chacc_pkg::CELL_ID_W'(32'(i_z_cell) * PHI_CELLS
                                                + 32'(i_phi_cell));
        o_item.energy  = i_deposit_energy;
        priority if (i_cmd == chacc_pkg::CMD_START) begin
            o_item.kind = chacc_pkg::KIND_START;
        end else if (i_deposit_energy == '0) begin
            o_item.kind = chacc_pkg::KIND_DROP;
        end else if (z_bad || phi_bad) begin
            o_item.kind = chacc_pkg::KIND_BAD;
        end else begin
            o_item.kind = chacc_pkg::KIND_DEPOSIT;
        end
    end

endmodule

`default_nettype wire

>>> src/chacc_fifo.sv
// Short queue of classified transactions between front and back.
// Depends on chacc_pkg.
`default_nettype none

module chacc_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire chacc_pkg::t_qitem i_item,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output chacc_pkg::t_qitem      o_item
);

    chacc_pkg::t_qitem                 r_buf [chacc_pkg::QUEUE_DEPTH];
    logic [chacc_pkg::QPTR_W-1:0]      r_wptr, n_wptr;
    logic [chacc_pkg::QPTR_W-1:0]      r_rptr, n_rptr;
    logic [chacc_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    logic                              do_push;
    logic                              do_pop;

    assign o_full  = r_cnt == chacc_pkg::QCNT_W'(chacc_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_buf[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update
    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> src/chacc_back.sv
// Back end: cell map memory with epoch marks, hit allocation, saturating
// accumulation and the result register. Depends on chacc_pkg.
`default_nettype none

module chacc_back #(
    parameter int NUM_CELLS   = 960,
    parameter int ENERGY_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    input  wire chacc_pkg::t_qitem     i_q_item,
    output logic                       o_pop,
    output chacc_pkg::t_bstat          o_stat,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output chacc_pkg::t_result         o_result
);

    localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W   = $clog2(NUM_CELLS + 1);
    localparam int SUM_W   = ((ENERGY_BITS > chacc_pkg::DEP_W) ?
                              ENERGY_BITS : chacc_pkg::DEP_W) + 1;
    localparam int EXT_W   = (ENERGY_BITS > chacc_pkg::OUT_E_W) ?
                             ENERGY_BITS : chacc_pkg::OUT_E_W;
    localparam logic [ENERGY_BITS-1:0] ACC_MAX = '1;

    typedef struct packed {
        logic [chacc_pkg::EPOCH_W-1:0] epoch;
        logic [CELL_AW-1:0]            idx;
        logic [ENERGY_BITS-1:0]        energy;
    } t_entry;

    t_entry                        r_mem [NUM_CELLS];
    t_entry                        r_rdata;
    chacc_pkg::t_bstate            r_state, n_state;
    logic [CELL_AW-1:0]            r_sweep_addr, n_sweep_addr;
    logic [chacc_pkg::EPOCH_W-1:0] r_epoch, n_epoch;
    logic [CNT_W-1:0]              r_hits, n_hits;
    chacc_pkg::t_qitem             r_cur, n_cur;
    chacc_pkg::t_result            r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic                          mem_we;
    logic [CELL_AW-1:0]            mem_waddr;
    t_entry                        mem_wdata;
    logic [CELL_AW-1:0]            mem_raddr;

    logic                          hit;
    logic [ENERGY_BITS-1:0]        old_e;
    logic [SUM_W-1:0]              sum;
    logic [ENERGY_BITS-1:0]        new_e;
    logic [EXT_W-1:0]              ext_e;
    logic [chacc_pkg::OUT_E_W-1:0] out_e;
    logic [CELL_AW-1:0]            idx;
    logic [CNT_W-1:0]              hits_inc;

    // Read-modify-write datapath for the current deposit
    assign mem_raddr = i_q_item.cell_id[CELL_AW-1:0];
    assign hit       = r_rdata.epoch == r_epoch;
    assign old_e     = hit ? r_rdata.energy : '0;
    assign sum       = SUM_W'(old_e) + SUM_W'(r_cur.energy);
    assign new_e     = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[ENERGY_BITS-1:0];
    assign ext_e     = EXT_W'(new_e);
    assign out_e     = (ext_e > EXT_W'({chacc_pkg::OUT_E_W{1'b1}})) ? '1 :
                       ext_e[chacc_pkg::OUT_E_W-1:0];
    assign idx       = hit ? r_rdata.idx : CELL_AW'(r_hits);
    assign hits_inc  = r_hits + 1'b1;

    assign o_valid         = r_out_valid;
    assign o_result        = r_out;
    assign o_stat.sweeping = r_state == chacc_pkg::BS_SWEEP;
    assign o_stat.busy     = r_state == chacc_pkg::BS_READ;

    // Next state and outputs
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_epoch      = r_epoch;
        n_hits       = r_hits;
        n_cur        = r_cur;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        mem_we       = 1'b0;
        mem_waddr    = r_cur.cell_id[CELL_AW-1:0];
        mem_wdata    = '0;
        o_pop        = 1'b0;
        unique case (r_state)
            chacc_pkg::BS_SWEEP: begin
                mem_we          = 1'b1;
                mem_waddr       = r_sweep_addr;
                mem_wdata.epoch = chacc_pkg::EPOCH_CLEAR;
                if (r_sweep_addr == CELL_AW'(NUM_CELLS - 1)) begin
                    n_state = chacc_pkg::BS_IDLE;
                    n_epoch = chacc_pkg::EPOCH_FIRST;
                end else begin
                    n_sweep_addr = r_sweep_addr + 1'b1;
                end
            end
            chacc_pkg::BS_IDLE: begin
                if (i_q_valid && (!r_out_valid || i_ready)) begin
                    o_pop           = 1'b1;
                    n_out           = '0;
                    n_out.hit_count = chacc_pkg::OUT_CNT_W'(r_hits);
                    unique case (i_q_item.kind)
                        chacc_pkg::KIND_START: begin
                            n_out_valid = 1'b1;
                            n_hits      = '0;
                            if (r_epoch == chacc_pkg::EPOCH_LAST) begin
                                n_state      = chacc_pkg::BS_SWEEP;
                                n_sweep_addr = '0;
                            end else begin
                                n_epoch = r_epoch + 1'b1;
                            end
                        end
                        chacc_pkg::KIND_DROP: begin
                            n_out_valid   = 1'b1;
                            n_out.dropped = 1'b1;
                        end
                        chacc_pkg::KIND_BAD: begin
                            n_out_valid    = 1'b1;
                            n_out.bad_cell = 1'b1;
                        end
                        chacc_pkg::KIND_DEPOSIT: begin
                            n_cur   = i_q_item;
                            n_state = chacc_pkg::BS_READ;
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            chacc_pkg::BS_READ: begin
                // Output slot is free here: it was free when this deposit was popped
                mem_we           = 1'b1;
                mem_wdata.epoch  = r_epoch;
                mem_wdata.idx    = idx;
                mem_wdata.energy = new_e;
                n_out.dropped     = 1'b0;
                n_out.bad_cell    = 1'b0;
                n_out.new_hit     = !hit;
                n_out.hit_index   = chacc_pkg::OUT_IDX_W'(idx);
                n_out.cell_energy = out_e;
                n_out.hit_count   = chacc_pkg::OUT_CNT_W'(hit ? r_hits : hits_inc);
                n_out_valid       = 1'b1;
                if (!hit) begin
                    n_hits = hits_inc;
                end
                n_state = chacc_pkg::BS_IDLE;
            end
            default: begin
                n_state = chacc_pkg::BS_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= chacc_pkg::BS_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= chacc_pkg::EPOCH_FIRST;
            r_hits       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_epoch      <= n_epoch;
            r_hits       <= n_hits;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    // Cell map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

`default_nettype wire

>>> src/cell_hit_accumulator_top.sv
// Cell hit accumulator: front classifies, queue decouples, back accumulates.
// Result register: loaded in the read state for a deposit (cell map read, then write), at the pop otherwise.
// Throughput: no item is popped during a deposit's write; other items one per cycle while results are taken.
// Reset: synchronous active low; a clearing pass over all Z_CELLS*PHI_CELLS cells follows
// reset and every 255th start-event, taking no queued transaction meanwhile.
// Depends on chacc_pkg, chacc_front, chacc_fifo, chacc_back and the macros header.
`default_nettype none
`include "cell_hit_accumulator_top_macros.svh"

module cell_hit_accumulator_top #(
    parameter int Z_CELLS     = 20,
    parameter int PHI_CELLS   = 48,
    parameter int ENERGY_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic                                i_cmd,
    input  wire logic [4:0]                          i_z_cell,
    input  wire logic [5:0]                          i_phi_cell,
    input  wire logic [chacc_pkg::DEP_W-1:0]         i_deposit_energy,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_dropped,
    output logic                                     o_bad_cell,
    output logic                                     o_new_hit,
    output logic [chacc_pkg::OUT_IDX_W-1:0]          o_hit_index,
    output logic [chacc_pkg::OUT_E_W-1:0]            o_cell_energy,
    output logic [chacc_pkg::OUT_CNT_W-1:0]          o_hit_count
);

    localparam int NUM_CELLS = Z_CELLS * PHI_CELLS;

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    chacc_pkg::t_qitem     q_in;
    chacc_pkg::t_qitem     q_out;
    chacc_pkg::t_bstat     b_stat;
    chacc_pkg::t_result    result;

    chacc_front #(
        .Z_CELLS   (Z_CELLS),
        .PHI_CELLS (PHI_CELLS)
    ) u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_z_cell         (i_z_cell),
        .i_phi_cell       (i_phi_cell),
        .i_deposit_energy (i_deposit_energy),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_item           (q_in)
    );

    chacc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    chacc_back #(
        .NUM_CELLS   (NUM_CELLS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_out),
        .o_pop     (q_pop),
        .o_stat    (b_stat),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_dropped     = result.dropped;
    assign o_bad_cell    = result.bad_cell;
    assign o_new_hit     = result.new_hit;
    assign o_hit_index   = result.hit_index;
    assign o_cell_energy = result.cell_energy;
    assign o_hit_count   = result.hit_count;

    // At most one outcome flag per result
    `CHACC_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, o_valid, $onehot0({o_dropped, o_bad_cell, o_new_hit}))
    // A new hit takes the last allocated index
    `CHACC_ASSERT_IMPL(a_new_idx, i_clk, i_rst_n, o_valid && o_new_hit, o_hit_index == (o_hit_count - 10'd1))
    // No queued transaction is taken while the cell map is being cleared
    `CHACC_ASSERT_IMPL(a_sweep_hold, i_clk, i_rst_n, b_stat.sweeping, !q_pop)
    // A deposit in progress always delivers a result on the next edge
    `CHACC_ASSERT_NEXT(a_read_done, i_clk, i_rst_n, b_stat.busy, o_valid && !b_stat.busy)

endmodule

`default_nettype wire
